[rtl/linear_key_value_table_defines.svh]
// Assertion helpers used by the table's back end, lkv_back.
// Each macro expects clk and rst to be visible where it is used.
`ifndef LINEAR_KEY_VALUE_TABLE_DEFINES_SVH
`define LINEAR_KEY_VALUE_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define LKV_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define LKV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/lkv_pkg.sv]
`default_nettype none

package lkv_pkg;

  localparam int CAPACITY    = 64;
  localparam int KEY_WIDTH   = 32;
  localparam int VALUE_WIDTH = 32;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // func codes on the request channel
  localparam logic [2:0] FUNC_ACCESS = 3'd0;
  localparam logic [2:0] FUNC_WRITE  = 3'd1;
  localparam logic [2:0] FUNC_LOOKUP = 3'd2;
  localparam logic [2:0] FUNC_ERASE  = 3'd3;
  localparam logic [2:0] FUNC_CLEAR  = 3'd4;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_ACCESS,
    OP_WRITE,
    OP_LOOKUP,
    OP_ERASE,
    OP_CLEAR
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_UPD,
    BK_DONE
  } bk_state_t;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] key;
    logic [31:0]        write_value;
  } req_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic        found;
    logic [1:0]  status;
    logic [6:0]  entry_count;
  } rsp_t;

  typedef struct packed {
    op_t                    op;
    logic [KEY_WIDTH-1:0]   key;
    logic [VALUE_WIDTH-1:0] value;
  } cmd_t;

  // OR-encode a vector with at most one bit set into its index.
  function automatic logic [IDX_W-1:0] onehot_to_index(input logic [CAPACITY-1:0] v);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (v[i]) begin
        idx = idx | IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

[rtl/lkv_front.sv]
`default_nettype none

module lkv_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire lkv_pkg::req_t req,
  output logic               cmd_valid,
  input  wire logic          cmd_ready,
  output lkv_pkg::cmd_t      cmd
);
  import lkv_pkg::*;

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  cmd_t              decoded;
  logic              push;
  logic              pop;

  // classify the request
  always_comb begin
    decoded.key   = req.key[KEY_WIDTH-1:0];
    decoded.value = req.write_value[VALUE_WIDTH-1:0];
    case (req.func)
      FUNC_ACCESS: decoded.op = OP_ACCESS;
      FUNC_WRITE:  decoded.op = OP_WRITE;
      FUNC_LOOKUP: decoded.op = OP_LOOKUP;
      FUNC_ERASE:  decoded.op = OP_ERASE;
      FUNC_CLEAR:  decoded.op = OP_CLEAR;
      default:     decoded.op = OP_NOP;
    endcase
  end

  assign req_ready = (fill != QCNT_W'(QUEUE_DEPTH));
  assign cmd_valid = (fill != '0);
  assign cmd       = slots[rd_ptr];
  assign push      = req_valid && req_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= decoded;
    end
  end

endmodule

`default_nettype wire

[rtl/lkv_back.sv]
`default_nettype none
`include "linear_key_value_table_defines.svh"

module lkv_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  output logic               cmd_ready,
  input  wire lkv_pkg::cmd_t cmd,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output lkv_pkg::rsp_t      rsp
);
  import lkv_pkg::*;

  bk_state_t              state;
  bk_state_t              state_next;
  cmd_t                   item;
  logic [KEY_WIDTH-1:0]   keys [CAPACITY];
  logic [VALUE_WIDTH-1:0] values [CAPACITY];
  logic [CAPACITY-1:0]    valid;
  logic [CAPACITY-1:0]    hit_vec;
  logic [CAPACITY-1:0]    free_vec;
  logic [CNT_W-1:0]       count;
  logic [VALUE_WIDTH-1:0] rd_value;
  logic                   found_r;
  status_t                status_r;

  logic                   have_hit;
  logic                   have_free;
  logic [CAPACITY-1:0]    first_free;
  logic [IDX_W-1:0]       hit_idx;
  logic [IDX_W-1:0]       free_idx;
  logic                   found_n;
  status_t                status_n;
  logic                   do_insert;
  logic                   do_erase;
  logic                   do_clear;
  logic                   vwr_en;
  logic [IDX_W-1:0]       vwr_idx;
  logic [VALUE_WIDTH-1:0] vwr_data;
  logic                   take;
  logic                   load_rsp;

  assign have_hit   = |hit_vec;
  assign have_free  = |free_vec;
  assign first_free = free_vec & (~free_vec + 1'b1);
  assign hit_idx    = onehot_to_index(hit_vec);
  assign free_idx   = onehot_to_index(first_free);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: if (cmd_valid) state_next = BK_UPD;
      BK_UPD:  state_next = BK_DONE;
      BK_DONE: if (!rsp_valid || rsp_ready) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  // outputs and update decisions
  always_comb begin
    cmd_ready = (state == BK_IDLE);
    load_rsp  = (state == BK_DONE) && (!rsp_valid || rsp_ready);
    found_n   = 1'b0;
    status_n  = ST_OK;
    do_insert = 1'b0;
    do_erase  = 1'b0;
    do_clear  = 1'b0;
    vwr_en    = 1'b0;
    vwr_idx   = hit_idx;
    vwr_data  = item.value;
    if (state == BK_UPD) begin
      case (item.op)
        OP_ACCESS, OP_WRITE: begin
          if (have_hit) begin
            found_n = 1'b1;
            vwr_en  = (item.op == OP_WRITE);
          end else if (have_free && (count < CAP_CNT)) begin
            do_insert = 1'b1;
            vwr_en    = 1'b1;
            vwr_idx   = free_idx;
            vwr_data  = (item.op == OP_WRITE) ? item.value : '0;
          end else begin
            status_n = ST_FULL;
          end
        end
        OP_LOOKUP: found_n = have_hit;
        OP_ERASE: begin
          if (have_hit) begin
            found_n  = 1'b1;
            do_erase = 1'b1;
          end else begin
            status_n = ST_MISSING;
          end
        end
        OP_CLEAR: do_clear = 1'b1;
        default: ;
      endcase
    end
  end

  assign take = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      valid     <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (do_clear) begin
        valid <= '0;
        count <= '0;
      end else if (do_insert) begin
        valid[free_idx] <= 1'b1;
        count           <= count + 1'b1;
      end else if (do_erase) begin
        valid[hit_idx] <= 1'b0;
        if (count != '0) begin
          count <= count - 1'b1;
        end
      end
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // compare all entries at once, hold the match and free vectors; also store inserted keys and register the response
  always_ff @(posedge clk) begin
    if (take) begin
      item <= cmd;
      for (int i = 0; i < CAPACITY; i++) begin
        hit_vec[i]  <= valid[i] && (keys[i] == cmd.key);
        free_vec[i] <= !valid[i];
      end
    end
    if (do_insert) begin
      keys[free_idx] <= item.key;
    end
    if (state == BK_UPD) begin
      found_r  <= found_n;
      status_r <= status_n;
    end
    if (load_rsp) begin
      rsp.read_value  <= found_r ? 32'(rd_value) : 32'd0;
      rsp.found       <= found_r;
      rsp.status      <= status_r;
      rsp.entry_count <= 7'(count);
    end
  end

  // value memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (vwr_en) begin
      values[vwr_idx] <= vwr_data;
    end
    if (state == BK_UPD) begin
      rd_value <= values[hit_idx];
    end
  end

  `LKV_ASSERT(a_count_tracks_valid, 1'b1, CNT_W'($countones(valid)) == count, "count out of step")
  `LKV_ASSERT(a_count_bound, 1'b1, count <= CAP_CNT, "count above capacity")
  `LKV_ASSERT(a_single_hit, state == BK_UPD, $onehot0(hit_vec), "key stored twice")
  `LKV_ASSERT_NEXT(a_clear_empties, do_clear, (valid == '0) && (count == '0), "clear left entries")

endmodule

`default_nettype wire

[rtl/linear_key_value_table.sv]
// Key/value table searched by exact key match, up to 64 entries.
// Request channel (req_valid/req_ready/req): func, key, write_value.
//   func selects access-or-insert, write-or-insert, lookup, erase or clear; other codes change nothing.
// Response channel (rsp_valid/rsp_ready/rsp): read_value, found, status,
//   entry_count; exactly one response per request, in request order.
// A request passes through the queue, then the back end's compare, update and
//   deliver states, before its response is registered.
// The back end takes one request at a time and finishes its compare / update /
//   deliver sequence on the single key store before it takes the next.
// A two-entry queue behind the request port lets requests transfer while
//   the back end works or the response waits.
// Reset empties the table (all entries invalid, count zero) and drops any
//   queued requests and any undelivered response.
// While rsp_ready is low the response holds; the back end stalls with its
//   finished item, and once the queue fills req_ready drops.
`default_nettype none

module linear_key_value_table (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire lkv_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output lkv_pkg::rsp_t      rsp
);
  import lkv_pkg::*;

  // transfer path between the decode queue and the table engine
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  // accept and classify requests, hold them in the queue
  lkv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  // search, update and answer, one command at a time
  lkv_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

[tb/lkv_table_scoreboard.sv]
package lkv_tb_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  import lkv_pkg::*;

  // Shadow copy of the table plus the responses it owes, oldest first.
  class lkv_table_scoreboard;
    logic [KEY_WIDTH-1:0]   shadow_key   [CAPACITY];
    logic [VALUE_WIDTH-1:0] shadow_value [CAPACITY];
    bit                     shadow_used  [CAPACITY];
    int unsigned            shadow_count;
    rsp_t                   owed_rsp     [$];
    int                     errors;

    function new();
      foreach (shadow_used[i]) shadow_used[i] = 1'b0;
      shadow_count = 0;
      errors       = 0;
    endfunction

    function int pending();
      return owed_rsp.size();
    endfunction

    // Apply one accepted request to the shadow table and queue its response.
    function void apply_request(req_t r);
      logic [KEY_WIDTH-1:0]   k;
      logic [VALUE_WIDTH-1:0] wv;
      int                     hit;
      int                     slot;
      rsp_t                   want;
      k    = KEY_WIDTH'(r.key);
      wv   = VALUE_WIDTH'(r.write_value);
      hit  = -1;
      slot = -1;
      for (int i = 0; i < CAPACITY; i++) begin
        if (shadow_used[i]) begin
          if (hit < 0 && shadow_key[i] == k) hit = i;
        end else if (slot < 0) begin
          slot = i;
        end
      end
      want = '0;
      case (r.func)
        FUNC_ACCESS, FUNC_WRITE: begin
          if (hit >= 0) begin
            want.read_value = 32'(shadow_value[hit]);
            want.found      = 1'b1;
            if (r.func == FUNC_WRITE) shadow_value[hit] = wv;
          end else if (slot >= 0 && shadow_count < CAPACITY) begin
            shadow_used[slot]  = 1'b1;
            shadow_key[slot]   = k;
            shadow_value[slot] = (r.func == FUNC_WRITE) ? wv : '0;
            shadow_count++;
          end else begin
            want.status = ST_FULL;
          end
        end
        FUNC_LOOKUP: begin
          if (hit >= 0) begin
            want.read_value = 32'(shadow_value[hit]);
            want.found      = 1'b1;
          end
        end
        FUNC_ERASE: begin
          if (hit >= 0) begin
            want.read_value   = 32'(shadow_value[hit]);
            want.found        = 1'b1;
            shadow_used[hit]  = 1'b0;
            if (shadow_count > 0) shadow_count--;
          end else begin
            want.status = ST_MISSING;
          end
        end
        FUNC_CLEAR: begin
          foreach (shadow_used[i]) shadow_used[i] = 1'b0;
          shadow_count = 0;
        end
        default: ;
      endcase
      want.entry_count = 7'(shadow_count);
      owed_rsp.push_back(want);
    endfunction

    function void report_field(string field, logic [31:0] want, logic [31:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endfunction

    // Compare one delivered response against the oldest owed one.
    function void check_response(rsp_t got);
      rsp_t want;
      if (owed_rsp.size() == 0) begin
        errors++;
        $display("%0t: response with none expected, expected nothing, actual %h",
                 $time, got);
        return;
      end
      want = owed_rsp.pop_front();
      if (got.read_value !== want.read_value)
        report_field("read_value", want.read_value, got.read_value);
      if (got.found !== want.found)
        report_field("found", 32'(want.found), 32'(got.found));
      if (got.status !== want.status)
        report_field("status", 32'(want.status), 32'(got.status));
      if (got.entry_count !== want.entry_count)
        report_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
    endfunction
  endclass

endpackage

[tb/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lkv_pkg::*;
  import lkv_tb_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 300;
  localparam int POOL_SIZE   = 96;
  localparam int PHASES      = 14;
  localparam int PHASE_ITEMS = 100;

  // First of the three func codes that the block treats as no operation.
  localparam logic [2:0] FUNC_SPARE = 3'd5;

  localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;

  // Operation mix of one random phase.
  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_CHURN} mix_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  lkv_table_scoreboard table_sb;

  // Keys drawn from a pool so that hits, refills and a full table all happen.
  logic signed [31:0] key_pool [POOL_SIZE];

  bit quiet_phase   = 1'b0;
  int holds_asked   = 0;
  int holds_taken   = 0;
  int hold_left     = 0;
  int rsp_idle_left = 0;
  int cycle_count   = 0;

  linear_key_value_table DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #10 clk = ~clk;

  // Idle length: mostly none, often a few cycles, now and then a long one.
  function automatic int idle_gap();
    int pick;
    pick = $urandom_range(99);
    if (quiet_phase || pick < 60) return 0;
    if (pick < 88) return $urandom_range(3, 1);
    if (pick < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic req_t make_req(logic [2:0] func, logic signed [31:0] key,
                                    logic [31:0] value);
    req_t r;
    r.func        = func;
    r.key         = key;
    r.write_value = value;
    return r;
  endfunction

  function automatic req_t random_request(mix_t mix, int span);
    int                 pick;
    int                 vpick;
    logic [2:0]         func;
    logic signed [31:0] key;
    logic [31:0]        value;
    pick = $urandom_range(99);
    case (mix)
      MIX_FILL: begin
        func = pick < 45 ? FUNC_WRITE  :
               pick < 75 ? FUNC_ACCESS :
               pick < 88 ? FUNC_LOOKUP :
               pick < 99 ? FUNC_ERASE  : FUNC_CLEAR;
      end
      MIX_DRAIN: begin
        func = pick < 10 ? FUNC_WRITE  :
               pick < 20 ? FUNC_ACCESS :
               pick < 40 ? FUNC_LOOKUP :
               pick < 98 ? FUNC_ERASE  : FUNC_CLEAR;
      end
      default: begin
        func = pick < 25 ? FUNC_WRITE  :
               pick < 45 ? FUNC_ACCESS :
               pick < 65 ? FUNC_LOOKUP :
               pick < 90 ? FUNC_ERASE  :
               pick < 92 ? FUNC_CLEAR  :
               pick < 94 ? 3'(FUNC_SPARE + $urandom_range(2)) : FUNC_LOOKUP;
      end
    endcase
    // Mostly pool keys so operations hit each other; the rest are wild.
    if ($urandom_range(99) < 85) key = key_pool[$urandom_range(span - 1)];
    else key = $signed($urandom);
    vpick = $urandom_range(99);
    value = vpick < 10 ? 32'h0000_0000 :
            vpick < 15 ? 32'hFFFF_FFFF : $urandom;
    return make_req(func, key, value);
  endfunction

  // Offer one request and hold it until the transfer; a nonzero gap then drops req_valid and idles.
  task automatic send_request(req_t item, int gap);
    req       <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    table_sb.apply_request(item);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every owed response has been delivered.
  task automatic wait_for_drain();
    if (req_valid) req_valid <= 1'b0;
    while (table_sb.pending() > 0) @(posedge clk);
  endtask

  // Response side: random ready gaps, plus one long hold-off on request so
  // that the request queue fills and req_ready drops.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (holds_taken != holds_asked) begin
      holds_taken = holds_taken + 1;
      hold_left   = HOLD_CYCLES;
      rsp_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      rsp_ready <= 1'b0;
    end else if (rsp_idle_left > 0) begin
      rsp_idle_left = rsp_idle_left - 1;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
      rsp_idle_left = idle_gap();
    end
  end

  // Check every response transfer against the shadow table.
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      table_sb.check_response(rsp);
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    mix_t mix;
    int   span;
    table_sb = new();
    foreach (key_pool[i]) key_pool[i] = $signed($urandom);
    key_pool[0] = KEY_MIN;
    key_pool[1] = KEY_MAX;
    key_pool[2] = 32'sh0000_0000;
    key_pool[3] = -32'sd1;
    key_pool[4] = 32'sh0000_0001;
    key_pool[5] = 32'sh5555_5555;
    key_pool[6] = 32'shAAAA_AAAA;

    // Hold reset from the start, then release it at a clock edge.
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty-table cases, inserts at the key extremes, replace,
    // erase present and missing, unused func codes, clear with a key.
    send_request(make_req(FUNC_CLEAR,  32'sh0, 32'h0), idle_gap());
    send_request(make_req(FUNC_LOOKUP, KEY_MIN, 32'h0), idle_gap());
    send_request(make_req(FUNC_ERASE,  KEY_MIN, 32'h0), idle_gap());
    send_request(make_req(FUNC_ACCESS, KEY_MIN, 32'hDEAD_BEEF), idle_gap());
    send_request(make_req(FUNC_WRITE,  KEY_MAX, 32'hFFFF_FFFF), idle_gap());
    send_request(make_req(FUNC_WRITE,  KEY_MAX, 32'h0000_0000), idle_gap());
    send_request(make_req(FUNC_ACCESS, KEY_MAX, 32'h1111_1111), idle_gap());
    send_request(make_req(FUNC_WRITE,  KEY_MIN, 32'h1234_5678), idle_gap());
    send_request(make_req(FUNC_LOOKUP, KEY_MIN, 32'hFFFF_FFFF), idle_gap());
    send_request(make_req(FUNC_WRITE,  32'sh0, 32'hAAAA_AAAA), idle_gap());
    send_request(make_req(FUNC_WRITE,  -32'sd1, 32'h5555_5555), idle_gap());
    send_request(make_req(FUNC_ACCESS, 32'sh1, 32'h0), idle_gap());
    send_request(make_req(FUNC_SPARE, 32'sh0, 32'hFFFF_FFFF), idle_gap());
    send_request(make_req(3'(FUNC_SPARE + 1), -32'sd1, 32'h0), idle_gap());
    send_request(make_req(3'(FUNC_SPARE + 2), KEY_MAX, 32'hFFFF_FFFF), idle_gap());
    send_request(make_req(FUNC_ERASE,  KEY_MAX, 32'h0), idle_gap());
    send_request(make_req(FUNC_LOOKUP, KEY_MAX, 32'h0), idle_gap());
    send_request(make_req(FUNC_ERASE,  KEY_MAX, 32'h0), idle_gap());
    send_request(make_req(FUNC_ERASE,  -32'sd1, 32'h0), idle_gap());
    send_request(make_req(FUNC_WRITE,  32'sh5555_5555, 32'h0), idle_gap());
    send_request(make_req(FUNC_LOOKUP, 32'sh0, 32'h0), idle_gap());
    send_request(make_req(FUNC_CLEAR,  32'sh1234, 32'hFFFF_FFFF), idle_gap());
    send_request(make_req(FUNC_LOOKUP, KEY_MIN, 32'h0), idle_gap());
    send_request(make_req(FUNC_ACCESS, KEY_MIN, 32'h0), idle_gap());
    send_request(make_req(FUNC_CLEAR,  32'sh0, 32'h0), idle_gap());
    wait_for_drain();

    // Fill with distinct keys past capacity so the last inserts see a full table.
    for (int i = 0; i < CAPACITY + 6; i++) begin
      send_request(make_req(FUNC_WRITE, key_pool[i], $urandom), idle_gap());
    end
    wait_for_drain();

    // Random phases cycling fill, drain and churn mixes. Every fourth phase, from
    // the second on, runs without idling, and one starts the long response hold-off.
    for (int phase = 0; phase < PHASES; phase++) begin
      mix         = mix_t'(phase % 3);
      span        = (mix == MIX_FILL) ? $urandom_range(POOL_SIZE, 48)
                                      : $urandom_range(POOL_SIZE, 4);
      quiet_phase = (phase % 4 == 1);
      if (phase == 2) holds_asked = holds_asked + 1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_request(random_request(mix, span), idle_gap());
      end
      if (phase % 3 == 2) wait_for_drain();
    end

    // Drain, let the pipeline settle, then report.
    wait_for_drain();
    repeat (20) @(posedge clk);
    if (table_sb.errors == 0 && table_sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/lkv_pkg.sv
rtl/lkv_front.sv
rtl/lkv_back.sv
rtl/linear_key_value_table.sv
tb/lkv_table_scoreboard.sv
tb/testbench.sv
